@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define MTP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// next-cycle implication, sampled on the rising clock edge, off during reset
`define MTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

@@ hw/rtl/mtp_pkg.sv @@
// ----------------------------------------------------------------------------
// mtp_pkg
// types, codes and constants of the millisecond timer pool
// ----------------------------------------------------------------------------
package mtp_pkg;

	localparam int SLOTS    = 10;
	localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int HANDLE_W = 4;
	localparam int COUNT_W  = 16;
	localparam int PRESC_W  = 7;

	localparam logic [PRESC_W-1:0]        TENTH_RELOAD = 7'd100;
	localparam logic signed [COUNT_W-1:0] MATCH_STOP   = 16'sh7FFF;

	localparam logic [2:0] CMD_TICK        = 3'd0;
	localparam logic [2:0] CMD_CREATE      = 3'd1;
	localparam logic [2:0] CMD_QUERY       = 3'd2;
	localparam logic [2:0] CMD_CLOSE       = 3'd3;
	localparam logic [2:0] CMD_LOAD_MATCH  = 3'd4;
	localparam logic [2:0] CMD_LOAD_DETECT = 3'd5;

	localparam logic [1:0] STATUS_RUNNING  = 2'd0;
	localparam logic [1:0] STATUS_FINISHED = 2'd1;
	localparam logic [1:0] STATUS_ERROR    = 2'd2;

	typedef struct packed {
		logic [2:0]                command;
		logic [HANDLE_W-1:0]       handle;
		logic [COUNT_W-1:0]        duration;
		logic signed [COUNT_W-1:0] match_value;
		logic [COUNT_W-1:0]        detect_value;
	} mtp_req_t;

	typedef struct packed {
		logic [HANDLE_W-1:0]       new_handle;
		logic [1:0]                query_status;
		logic [COUNT_W-1:0]        remaining;
		logic signed [COUNT_W-1:0] match_time;
		logic [COUNT_W-1:0]        detect_left;
	} mtp_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SWEEP,
		ST_DRAIN,
		ST_RESP
	} mtp_state_t;

	typedef struct packed {
		logic             capture;
		logic             tick_upd;
		logic             create;
		logic             close;
		logic             query_rd;
		logic             load_match;
		logic             load_detect;
		logic             sweep_rd;
		logic [IDX_W-1:0] sweep_idx;
		logic             respond;
	} mtp_ctl_t;

	typedef struct packed {
		logic [2:0] command;
	} mtp_sts_t;

endpackage

@@ hw/rtl/millisecond_timer_pool_core.sv @@
// ----------------------------------------------------------------------------
// millisecond_timer_pool_core
// pool of one-shot millisecond timers with match clock and detect timeout
// ----------------------------------------------------------------------------
// a word passes the dispatch and response states before done rises, a tick
// also the sweep and drain states; a new word is taken only while busy is low
// a tick walks the slot count memory one entry a cycle on read and write ports
// done pulses for one cycle; the receiver cannot stall, busy low means ready
// reset clears all slots to free, match clock to stop and detect timeout to zero
module millisecond_timer_pool_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mtp_pkg::mtp_req_t req,
	output logic              busy,
	output logic              done,
	output mtp_pkg::mtp_res_t result
);

	mtp_pkg::mtp_ctl_t ctl;
	mtp_pkg::mtp_sts_t sts;

	mtp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	mtp_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctl    (ctl),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

endmodule

@@ hw/rtl/mtp_ctrl.sv @@
// ----------------------------------------------------------------------------
// mtp_ctrl
// sequencer: dispatches a command word and walks the slots on a tick
// ----------------------------------------------------------------------------
module mtp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mtp_pkg::mtp_sts_t sts,
	output mtp_pkg::mtp_ctl_t ctl,
	output logic              busy
);

	mtp_pkg::mtp_state_t         state_q, state_nxt;
	logic [mtp_pkg::IDX_W-1:0]   idx_q, idx_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtp_pkg::ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_nxt;
			idx_q   <= idx_nxt;
		end
	end

	always_comb begin
		state_nxt     = state_q;
		idx_nxt       = '0;
		ctl           = '0;
		ctl.sweep_idx = idx_q;
		busy          = (state_q != mtp_pkg::ST_IDLE);
		unique case (state_q)
			mtp_pkg::ST_IDLE: begin
				if (start) begin
					ctl.capture = 1'b1;
					state_nxt   = mtp_pkg::ST_DISPATCH;
				end
			end
			mtp_pkg::ST_DISPATCH: begin
				state_nxt = mtp_pkg::ST_RESP;
				unique case (sts.command)
					mtp_pkg::CMD_TICK: begin
						ctl.tick_upd = 1'b1;
						state_nxt    = mtp_pkg::ST_SWEEP;
					end
					mtp_pkg::CMD_CREATE:      ctl.create      = 1'b1;
					mtp_pkg::CMD_QUERY:       ctl.query_rd    = 1'b1;
					mtp_pkg::CMD_CLOSE:       ctl.close       = 1'b1;
					mtp_pkg::CMD_LOAD_MATCH:  ctl.load_match  = 1'b1;
					mtp_pkg::CMD_LOAD_DETECT: ctl.load_detect = 1'b1;
					default: ;
				endcase
			end
			mtp_pkg::ST_SWEEP: begin
				ctl.sweep_rd = 1'b1;
				if (idx_q == mtp_pkg::IDX_W'(mtp_pkg::SLOTS - 1)) begin
					state_nxt = mtp_pkg::ST_DRAIN;
				end else begin
					idx_nxt = idx_q + mtp_pkg::IDX_W'(1);
				end
			end
			mtp_pkg::ST_DRAIN: begin
				state_nxt = mtp_pkg::ST_RESP;
			end
			mtp_pkg::ST_RESP: begin
				ctl.respond = 1'b1;
				state_nxt   = mtp_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = mtp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/mtp_datapath.sv @@
// ----------------------------------------------------------------------------
// mtp_datapath
// slot count memory, busy flags, match clock, detect counter, result register
// ----------------------------------------------------------------------------
module mtp_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  mtp_pkg::mtp_req_t req,
	input  mtp_pkg::mtp_ctl_t ctl,
	output mtp_pkg::mtp_sts_t sts,
	output logic              done,
	output mtp_pkg::mtp_res_t result
);

	mtp_pkg::mtp_req_t                  req_q;
	logic [mtp_pkg::SLOTS-1:0]          slot_busy_q;
	logic [mtp_pkg::COUNT_W-1:0]        mem [mtp_pkg::SLOTS];
	logic [mtp_pkg::COUNT_W-1:0]        rd_q;
	logic                               sweep_s1;
	logic [mtp_pkg::IDX_W-1:0]          idx_s1;
	logic [mtp_pkg::PRESC_W-1:0]        presc_q;
	logic signed [mtp_pkg::COUNT_W-1:0] match_q;
	logic [mtp_pkg::COUNT_W-1:0]        detect_q;
	logic [mtp_pkg::HANDLE_W-1:0]       nh_q;
	logic                               done_q;
	mtp_pkg::mtp_res_t                  res_q;

	logic                               free_found;
	logic [mtp_pkg::IDX_W-1:0]          free_idx;
	logic                               h_ok;
	logic [mtp_pkg::IDX_W-1:0]          h_idx;
	logic                               h_busy;
	logic                               rd_en;
	logic [mtp_pkg::IDX_W-1:0]          rd_addr;
	logic                               wr_en;
	logic [mtp_pkg::IDX_W-1:0]          wr_addr;
	logic [mtp_pkg::COUNT_W-1:0]        wr_data;
	logic [mtp_pkg::COUNT_W-1:0]        dec_data;
	logic [mtp_pkg::PRESC_W-1:0]        presc_eff;
	logic [mtp_pkg::PRESC_W-1:0]        presc_dec;
	logic [1:0]                         q_status;
	logic [mtp_pkg::COUNT_W-1:0]        q_remaining;

	assign sts.command = req_q.command;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = mtp_pkg::SLOTS - 1; i >= 0; i--) begin
			if (!slot_busy_q[i]) begin
				free_found = 1'b1;
				free_idx   = mtp_pkg::IDX_W'(i);
			end
		end
	end

	assign h_ok   = (req_q.handle != '0) && (int'(req_q.handle) <= mtp_pkg::SLOTS);
	assign h_idx  = mtp_pkg::IDX_W'(req_q.handle - mtp_pkg::HANDLE_W'(1));
	assign h_busy = h_ok && slot_busy_q[h_idx];

	assign dec_data = (slot_busy_q[idx_s1] && rd_q != '0) ?
		rd_q - mtp_pkg::COUNT_W'(1) : rd_q;

	assign rd_en   = ctl.sweep_rd || (ctl.query_rd && h_ok);
	assign rd_addr = ctl.sweep_rd ? ctl.sweep_idx : h_idx;
	assign wr_en   = sweep_s1 || (ctl.create && free_found);
	assign wr_addr = sweep_s1 ? idx_s1 : free_idx;
	assign wr_data = sweep_s1 ? dec_data : req_q.duration;

	assign presc_eff = (match_q == mtp_pkg::MATCH_STOP) ? mtp_pkg::TENTH_RELOAD : presc_q;
	assign presc_dec = presc_eff - mtp_pkg::PRESC_W'(1);

	// query answer
	always_comb begin
		q_status    = '0;
		q_remaining = '0;
		if (req_q.command == mtp_pkg::CMD_QUERY) begin
			if (h_busy) begin
				q_status    = (rd_q != '0) ? mtp_pkg::STATUS_RUNNING : mtp_pkg::STATUS_FINISHED;
				q_remaining = rd_q;
			end else begin
				q_status = mtp_pkg::STATUS_ERROR;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			req_q <= req;
		end
		if (ctl.sweep_rd) begin
			idx_s1 <= ctl.sweep_idx;
		end
		if (ctl.create) begin
			nh_q <= free_found ? mtp_pkg::HANDLE_W'(free_idx) + mtp_pkg::HANDLE_W'(1) : '0;
		end
		if (ctl.respond) begin
			res_q.new_handle   <= (req_q.command == mtp_pkg::CMD_CREATE) ? nh_q : '0;
			res_q.query_status <= q_status;
			res_q.remaining    <= q_remaining;
			res_q.match_time   <= match_q;
			res_q.detect_left  <= detect_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_busy_q <= '0;
			sweep_s1    <= 1'b0;
			presc_q     <= mtp_pkg::TENTH_RELOAD;
			match_q     <= mtp_pkg::MATCH_STOP;
			detect_q    <= '0;
			done_q      <= 1'b0;
		end else begin
			sweep_s1 <= ctl.sweep_rd;
			done_q   <= ctl.respond;
			if (ctl.create && free_found) begin
				slot_busy_q[free_idx] <= 1'b1;
			end
			if (ctl.close && h_ok) begin
				slot_busy_q[h_idx] <= 1'b0;
			end
			if (ctl.load_match) begin
				match_q <= req_q.match_value;
			end
			if (ctl.load_detect) begin
				detect_q <= req_q.detect_value;
			end
			if (ctl.tick_upd) begin
				if (detect_q != '0) begin
					detect_q <= detect_q - mtp_pkg::COUNT_W'(1);
				end
				if (presc_dec == '0) begin
					presc_q <= mtp_pkg::TENTH_RELOAD;
					if (match_q != mtp_pkg::MATCH_STOP) begin
						match_q <= match_q - mtp_pkg::COUNT_W'(1);
					end
				end else begin
					presc_q <= presc_dec;
				end
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

@@ hw/rtl/mtp_checker.sv @@
// ----------------------------------------------------------------------------
// mtp_checker
// port-level checks on the timer pool handshake and result words
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mtp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input mtp_pkg::mtp_res_t result
);

	logic status_odd;
	logic error_clean;

	assign status_odd = (result.query_status != mtp_pkg::STATUS_RUNNING) &&
		(result.query_status != mtp_pkg::STATUS_FINISHED);
	assign error_clean = (result.query_status == mtp_pkg::STATUS_ERROR) &&
		(result.remaining == '0);

	`MTP_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`MTP_ASSERT_NEXT(a_accept_no_done, clk, arst_n, start && !busy, !done)
	`MTP_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy)
	`MTP_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`MTP_ASSERT_NOW(a_error_no_time, clk, arst_n, done && status_odd, error_clean)

endmodule

bind millisecond_timer_pool_core mtp_checker u_mtp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

@@ test/millisecond_timer_pool_core_tb.sv @@
// ----------------------------------------------------------------------------
// millisecond_timer_pool_core_tb
// self-checking bench for the millisecond timer pool: a directed opening
// (handle extremes, full pool, close of free slots, match and detect loads,
// spare commands) is followed by random command sequences with tick runs that
// drain timers, roll the match clock past -32768 and count the detect timeout
// out; every result word is checked field by field against an in-bench
// model of the pool
// ----------------------------------------------------------------------------
module millisecond_timer_pool_core_tb;
	import mtp_pkg::*;

	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;
	localparam int WORD_TARGET  = 800;
	localparam int CALM_TAIL    = 100;
	localparam int SETTLE_CYCLES = 24;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct {
		mtp_req_t word;
		bit       hold;
	} backlog_entry_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	mtp_req_t req = '0;
	logic     busy;
	logic     done;
	mtp_res_t result;

	backlog_entry_t command_backlog[$];
	mtp_res_t       pending_results[$];

	logic [COUNT_W-1:0]        timer_count[SLOTS];
	logic                      timer_busy[SLOTS];
	logic [PRESC_W-1:0]        tenth_div;
	logic signed [COUNT_W-1:0] match_clk;
	logic [COUNT_W-1:0]        detect_cnt;

	int  failures = 0;
	int  cycle_count = 0;
	int  words_built = 0;
	int  accepted = 0;
	int  sender_gap = 0;
	bit  idle_phase = 1'b1;

	millisecond_timer_pool_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void clear_timer_pool();
		for (int i = 0; i < SLOTS; i++) begin
			timer_count[i] = '0;
			timer_busy[i] = 1'b0;
		end
		tenth_div = TENTH_RELOAD;
		match_clk = MATCH_STOP;
		detect_cnt = '0;
	endfunction

	function automatic mtp_res_t timer_pool_predict(mtp_req_t w);
		mtp_res_t r;
		bit       found;
		int       h;
		r = '0;
		found = 1'b0;
		h = w.handle;
		case (w.command)
			CMD_TICK: begin
				for (int i = 0; i < SLOTS; i++)
					if (timer_busy[i] && timer_count[i] != '0)
						timer_count[i] = timer_count[i] - COUNT_W'(1);
				if (detect_cnt != '0)
					detect_cnt = detect_cnt - COUNT_W'(1);
				if (match_clk == MATCH_STOP)
					tenth_div = TENTH_RELOAD;
				tenth_div = tenth_div - PRESC_W'(1);
				if (tenth_div == '0) begin
					tenth_div = TENTH_RELOAD;
					if (match_clk != MATCH_STOP)
						match_clk = match_clk - 16'sd1;
				end
			end
			CMD_CREATE: begin
				for (int i = 0; i < SLOTS; i++)
					if (!found && !timer_busy[i]) begin
						found = 1'b1;
						timer_count[i] = w.duration;
						timer_busy[i] = 1'b1;
						r.new_handle = HANDLE_W'(i + 1);
					end
			end
			CMD_QUERY: begin
				if (h >= 1 && h <= SLOTS && timer_busy[h-1]) begin
					r.remaining = timer_count[h-1];
					r.query_status = (timer_count[h-1] != '0) ? STATUS_RUNNING : STATUS_FINISHED;
				end else begin
					r.query_status = STATUS_ERROR;
				end
			end
			CMD_CLOSE: begin
				if (h >= 1 && h <= SLOTS) begin
					timer_busy[h-1] = 1'b0;
					timer_count[h-1] = '0;
				end
			end
			CMD_LOAD_MATCH: match_clk = w.match_value;
			CMD_LOAD_DETECT: detect_cnt = w.detect_value;
			default: ;
		endcase
		r.match_time = match_clk;
		r.detect_left = detect_cnt;
		return r;
	endfunction

	function automatic logic [15:0] rnd16();
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic logic [3:0] pick_handle();
		if ($urandom_range(0, 7) == 0)
			return 4'($urandom_range(0, 15));
		return 4'($urandom_range(1, SLOTS));
	endfunction

	function automatic logic [15:0] pick_duration();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return 16'($urandom_range(0, 40));
		if (r < 9)
			return 16'($urandom_range(0, 400));
		return rnd16();
	endfunction

	function automatic logic [15:0] pick_match();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h8001;
			2: return 16'h0000;
			3: return 16'h0001;
			4: return 16'h7FFE;
			5: return 16'h7FFF;
			6: return 16'($urandom_range(1, 3));
			default: return rnd16();
		endcase
	endfunction

	task automatic add_word(input logic [2:0] cmd, input logic [3:0] h, input logic [15:0] dur,
			input logic [15:0] mv, input logic [15:0] dv, input bit hold);
		backlog_entry_t e;
		e.word.command = cmd;
		e.word.handle = h;
		e.word.duration = dur;
		e.word.match_value = mv;
		e.word.detect_value = dv;
		e.hold = hold;
		command_backlog.push_back(e);
		words_built++;
	endtask

	task automatic add_random(input logic [2:0] cmd, input bit hold);
		add_word(cmd, 4'($urandom_range(0, 15)), rnd16(), rnd16(), rnd16(), hold);
	endtask

	task automatic add_ticks(input int n);
		for (int i = 0; i < n; i++)
			add_random(CMD_TICK, 1'b0);
	endtask

	// driver: one word in flight on start/req, accepted when busy is low
	always @(posedge clk) begin
		logic next_start;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			next_start = start;
			if (start && !busy) begin
				pending_results.push_back(timer_pool_predict(req));
				next_start = 1'b0;
				accepted++;
				if (accepted % 64 == 0)
					idle_phase = 1'($urandom_range(0, 1));
				if (idle_phase && command_backlog.size() > CALM_TAIL && $urandom_range(0, 2) == 0)
					sender_gap = $urandom_range(1, 4);
			end
			if (!next_start) begin
				// idle cycles count only while the block is ready
				if (sender_gap != 0 && !busy && !start)
					sender_gap--;
				if (sender_gap == 0 && command_backlog.size() != 0 &&
						!(command_backlog[0].hold && pending_results.size() != 0)) begin
					req <= command_backlog[0].word;
					command_backlog.pop_front();
					next_start = 1'b1;
				end
			end
			start <= next_start;
		end
	end

	// monitor: every done strobe carries one result word
	always @(posedge clk) begin
		mtp_res_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result word: %h", result);
				failures++;
			end else begin
				want = pending_results.pop_front();
				if (result.new_handle !== want.new_handle) begin
					$error("new_handle: expected %0d, got %0d", want.new_handle, result.new_handle);
					failures++;
				end
				if (result.query_status !== want.query_status) begin
					$error("query_status: expected %0d, got %0d", want.query_status,
						result.query_status);
					failures++;
				end
				if (result.remaining !== want.remaining) begin
					$error("remaining: expected %0d, got %0d", want.remaining, result.remaining);
					failures++;
				end
				if (result.match_time !== want.match_time) begin
					$error("match_time: expected %0d, got %0d", want.match_time, result.match_time);
					failures++;
				end
				if (result.detect_left !== want.detect_left) begin
					$error("detect_left: expected %0d, got %0d", want.detect_left, result.detect_left);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int n;
		int r;
		clear_timer_pool();

		// directed opening
		add_word(CMD_QUERY, 4'd0, rnd16(), rnd16(), rnd16(), 1'b0);
		add_word(CMD_QUERY, 4'd15, rnd16(), rnd16(), rnd16(), 1'b0);
		add_word(CMD_CREATE, 4'd0, 16'hFFFF, rnd16(), rnd16(), 1'b0);
		add_word(CMD_CREATE, 4'd15, 16'h0000, rnd16(), rnd16(), 1'b0);
		for (int i = 0; i < SLOTS - 2; i++)
			add_word(CMD_CREATE, 4'($urandom_range(0, 15)), 16'($urandom_range(1, 3)),
				rnd16(), rnd16(), 1'b0);
		add_word(CMD_CREATE, 4'd0, rnd16(), rnd16(), rnd16(), 1'b0);
		add_word(CMD_QUERY, 4'd1, rnd16(), rnd16(), rnd16(), 1'b0);
		add_word(CMD_QUERY, 4'd2, rnd16(), rnd16(), rnd16(), 1'b0);
		add_word(CMD_CLOSE, 4'd11, rnd16(), rnd16(), rnd16(), 1'b0);
		add_word(CMD_CLOSE, 4'd0, rnd16(), rnd16(), rnd16(), 1'b0);
		add_word(CMD_CLOSE, 4'd3, rnd16(), rnd16(), rnd16(), 1'b0);
		add_word(CMD_QUERY, 4'd3, rnd16(), rnd16(), rnd16(), 1'b0);
		add_word(CMD_CLOSE, 4'd3, rnd16(), rnd16(), rnd16(), 1'b0);
		add_word(CMD_CREATE, 4'd0, 16'h1234, rnd16(), rnd16(), 1'b0);
		add_word(CMD_LOAD_MATCH, 4'd0, rnd16(), 16'h7FFF, rnd16(), 1'b0);
		add_word(CMD_LOAD_DETECT, 4'd0, rnd16(), rnd16(), 16'hFFFF, 1'b0);
		add_word(CMD_TICK, 4'd0, rnd16(), rnd16(), rnd16(), 1'b0);
		add_word(CMD_LOAD_DETECT, 4'd0, rnd16(), rnd16(), 16'h0000, 1'b0);
		add_word(CMD_TICK, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		add_word(CMD_SPARE_A, 4'd5, rnd16(), rnd16(), rnd16(), 1'b0);
		add_word(CMD_SPARE_B, 4'd15, rnd16(), rnd16(), rnd16(), 1'b0);

		// match clock from the bottom of its range, rolling over to stop
		add_word(CMD_LOAD_MATCH, 4'd0, rnd16(), 16'h8000, rnd16(), 1'b1);
		add_ticks(201);

		while (words_built < WORD_TARGET) begin
			r = $urandom_range(0, 19);
			if (r < 10) begin
				n = $urandom_range(2, 10);
				for (int i = 0; i < n; i++) begin
					case ($urandom_range(0, 9))
						0, 1, 2: add_word(CMD_CREATE, 4'($urandom_range(0, 15)), pick_duration(),
							rnd16(), rnd16(), (i == 0) && ($urandom_range(0, 9) == 0));
						3, 4, 5: add_word(CMD_QUERY, pick_handle(), rnd16(), rnd16(), rnd16(), 1'b0);
						6: add_word(CMD_CLOSE, pick_handle(), rnd16(), rnd16(), rnd16(), 1'b0);
						default: add_ticks($urandom_range(1, 12));
					endcase
				end
			end else if (r < 16) begin
				if ($urandom_range(0, 1))
					add_word(CMD_LOAD_MATCH, 4'($urandom_range(0, 15)), rnd16(), pick_match(),
						rnd16(), 1'b0);
				if ($urandom_range(0, 2) == 0)
					add_word(CMD_LOAD_DETECT, 4'($urandom_range(0, 15)), rnd16(), rnd16(),
						($urandom_range(0, 4) == 0) ? rnd16() : 16'($urandom_range(0, 60)), 1'b0);
				if ($urandom_range(0, 5) == 0)
					add_ticks($urandom_range(100, 220));
				else
					add_ticks($urandom_range(1, 30));
			end else begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					add_random(3'($urandom_range(0, 7)), 1'b0);
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (command_backlog.size() != 0 || start || pending_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (failures == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ millisecond_timer_pool_core.f @@
+incdir+hw/rtl
hw/rtl/mtp_pkg.sv
hw/rtl/mtp_ctrl.sv
hw/rtl/mtp_datapath.sv
hw/rtl/millisecond_timer_pool_core.sv
hw/rtl/mtp_checker.sv
test/millisecond_timer_pool_core_tb.sv
